/* rtl/core/cfa_pkg.sv */
// Package: constants, widths and payload types for the custom float adder.
`default_nettype none
package cfa_pkg;
  localparam int EXP_BITS_DEF = 4;
  localparam int MAN_BITS_DEF = 28;
  localparam int WORD_BITS = 32;

  typedef struct packed {
    logic [WORD_BITS-1:0] operand_a;
    logic [WORD_BITS-1:0] operand_b;
  } in_item_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] sum_word;
    logic                 saturated;
  } out_item_t;
endpackage
`default_nettype wire

/* rtl/core/cfa_if.sv */
// Interfaces: valid/ready channels for operand pairs and sums.
`default_nettype none
interface cfa_in_if
  import cfa_pkg::*;
();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface cfa_out_if
  import cfa_pkg::*;
();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/core/custom_float_adder.sv */
// Top level: three-stage pipelined custom float adder.
//
//  channel   dir  payload
//  in_ch     in   operand_a, operand_b
//  out_ch    out  sum_word, saturated
//
// One operand pair per cycle while no stall holds the stages; the stages are
// unpack/align select, shift and add, carry fix and pack. Stages advance
// together when the output stage is empty or taken; a stall holds every
// stage in place. Synchronous reset clears the stage valid bits only.
`default_nettype none
module custom_float_adder
  import cfa_pkg::*;
#(
  parameter int EXP_BITS = EXP_BITS_DEF,
  parameter int MAN_BITS = MAN_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  cfa_in_if.sink    in_ch,
  cfa_out_if.source out_ch
);
  localparam int FULL = EXP_BITS + MAN_BITS;
  // wide enough for both the exponent difference and the mantissa width
  localparam int SH_BITS = (EXP_BITS > 7) ? EXP_BITS : 7;

  logic [2:0] vld;
  logic       adv;
  assign adv = !vld[2] || out_ch.ready;
  assign in_ch.ready = adv;

  // stage 1 unpack
  logic [FULL-1:0]     wa, wb;
  logic [EXP_BITS-1:0] ea, eb;
  logic [MAN_BITS-1:0] ma, mb;
  always_comb begin
    wa = '0;
    wb = '0;
    for (int i = 0; i < FULL; i++) begin
      if (i < WORD_BITS) begin
        wa[i] = in_ch.data.operand_a[i];
        wb[i] = in_ch.data.operand_b[i];
      end
    end
    ea = wa[FULL-1:MAN_BITS];
    eb = wb[FULL-1:MAN_BITS];
    ma = wa[MAN_BITS-1:0];
    mb = wb[MAN_BITS-1:0];
  end

  logic [EXP_BITS-1:0] s1_e;
  logic [MAN_BITS-1:0] s1_big, s1_small;
  logic [EXP_BITS-1:0] s1_diff;
  logic                s1_bad;

  // stage 2
  logic [MAN_BITS:0]   s2_m;
  logic [EXP_BITS-1:0] s2_e;
  logic                s2_bad;

  // stage 3
  out_item_t s3;

  logic [MAN_BITS-1:0] shifted;
  assign shifted = (SH_BITS'(s1_diff) >= SH_BITS'(MAN_BITS)) ? '0 : (s1_small >> s1_diff);

  logic [EXP_BITS:0]   e_fix;
  logic [MAN_BITS-1:0] m_fix;
  logic [FULL-1:0]     packed_w;
  always_comb begin
    e_fix = s2_m[MAN_BITS] ? ({1'b0, s2_e} + 1'b1) : {1'b0, s2_e};
    m_fix = s2_m[MAN_BITS] ? s2_m[MAN_BITS:1] : s2_m[MAN_BITS-1:0];
    packed_w = {e_fix[EXP_BITS-1:0], m_fix};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[1:0], in_ch.valid};
    end
    if (adv) begin
      s1_bad <= (ea != '0 && !ma[MAN_BITS-1]) || (eb != '0 && !mb[MAN_BITS-1]);
      if (ea >= eb) begin
        s1_e <= ea;
        s1_big <= ma;
        s1_small <= mb;
        s1_diff <= ea - eb;
      end else begin
        s1_e <= eb;
        s1_big <= mb;
        s1_small <= ma;
        s1_diff <= eb - ea;
      end
      s2_m <= {1'b0, s1_big} + {1'b0, shifted};
      s2_e <= s1_e;
      s2_bad <= s1_bad;
      if (s2_bad || e_fix[EXP_BITS]) begin
        s3.sum_word <= '1;
        s3.saturated <= 1'b1;
      end else begin
        s3.sum_word <= WORD_BITS'({{(WORD_BITS){1'b0}}, packed_w});
        s3.saturated <= 1'b0;
      end
    end
  end

  assign out_ch.valid = vld[2];
  assign out_ch.data = s3;
endmodule
`default_nettype wire
